>>> rtl/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted priority queue.
// No dependencies; used by the cell, the top level and the testbench.
package spq_pkg;

    localparam int MODE_W = 3;

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_ENQUEUE   = 3'd0;
    localparam mode_t MODE_POP       = 3'd1;
    localparam mode_t MODE_PEEK_TOP  = 3'd2;
    localparam mode_t MODE_PEEK_AT   = 3'd3;
    localparam mode_t MODE_REMOVE_AT = 3'd4;

    typedef struct packed {
        logic ins;       // enqueue transfer accepted
        logic del;       // removal transfer accepted
        logic valid;     // cell holds a live entry
        logic at_or_after; // cell sits at or above the removal position
    } cell_ctrl_t;

endpackage

>>> rtl/spq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the sorted priority queue chain.
// Depends on spq_pkg for the control struct.
module spq_cell #(
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic                      clk,
    input  spq_pkg::cell_ctrl_t       ctrl,
    input  logic [DATA_WIDTH-1:0]     new_data,
    input  logic [PRIORITY_WIDTH-1:0] new_prio,
    input  logic                      left_le,
    input  logic [DATA_WIDTH-1:0]     left_data,
    input  logic [PRIORITY_WIDTH-1:0] left_prio,
    input  logic [DATA_WIDTH-1:0]     right_data,
    input  logic [PRIORITY_WIDTH-1:0] right_prio,
    output logic                      le,
    output logic [DATA_WIDTH-1:0]     data,
    output logic [PRIORITY_WIDTH-1:0] prio
);

    logic [DATA_WIDTH-1:0]     data_reg;
    logic [DATA_WIDTH-1:0]     data_next;
    logic [PRIORITY_WIDTH-1:0] prio_reg;
    logic [PRIORITY_WIDTH-1:0] prio_next;

    assign le   = ctrl.valid && (prio_reg <= new_prio);
    assign data = data_reg;
    assign prio = prio_reg;

    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (ctrl.ins && !le)
        begin
            if (left_le)
            begin
                data_next = new_data;
                prio_next = new_prio;
            end
            else
            begin
                data_next = left_data;
                prio_next = left_prio;
            end
        end
        else if (ctrl.del && ctrl.at_or_after)
        begin
            data_next = right_data;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

endmodule

>>> rtl/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// Sorted priority queue built as a chain of storage cells.
// Depends on spq_pkg and spq_cell.
//
// Takes one operation per clock while s_tready is high and returns exactly one result for each,
// registered and presented in the cycle after the transfer. Every cell compares its own priority
// with the incoming one and shifts or loads in the same cycle, so enqueue, pop and remove all
// take effect in the chain at the transfer; the single output register lets a new operation be
// taken whenever the pending result is taken in the same cycle or none is pending. Peek, pop and
// remove select the addressed cell through a one-hot select over all DEPTH cells. No clearing
// pass: the queue is usable straight after reset.
module sorted_priority_queue_unit #(
    parameter int DEPTH          = 16,
    parameter int DATA_WIDTH     = 32,
    parameter int PRIORITY_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // mode, data_value, priority_req, index (lowest bit first), zero padded
    input  logic [((spq_pkg::MODE_W + DATA_WIDTH + PRIORITY_WIDTH + $clog2(DEPTH) + 7) / 8) * 8 - 1:0]
        s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // ok, data_out, count, empty_res, full_res (lowest bit first), zero padded
    output logic [((DATA_WIDTH + $clog2(DEPTH + 1) + 3 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_W = ((DATA_WIDTH + CW + 3 + 7) / 8) * 8;
    localparam int D_LO  = spq_pkg::MODE_W;
    localparam int P_LO  = D_LO + DATA_WIDTH;
    localparam int I_LO  = P_LO + PRIORITY_WIDTH;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    spq_pkg::mode_t            mode;
    logic [DATA_WIDTH-1:0]     in_data;
    logic [PRIORITY_WIDTH-1:0] in_prio;
    logic [IW-1:0]             in_index;

    logic          accept;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] sel_pos;
    logic          ok;
    logic          do_ins;
    logic          do_del;
    logic          do_read;
    logic [DATA_WIDTH-1:0] sel_data;
    logic [DATA_WIDTH-1:0] dout;

    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [OUT_W-1:0]      m_tdata_reg;
    logic [OUT_W-1:0]      m_tdata_next;

    logic                      cell_le   [DEPTH];
    logic [DATA_WIDTH-1:0]     cell_data [DEPTH];
    logic [PRIORITY_WIDTH-1:0] cell_prio [DEPTH];

    assign mode     = s_tdata[spq_pkg::MODE_W-1:0];
    assign in_data  = s_tdata[P_LO-1:D_LO];
    assign in_prio  = s_tdata[I_LO-1:P_LO];
    assign in_index = s_tdata[I_LO+IW-1:I_LO];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // decode the operation against the current fill level
    always_comb
    begin
        ok         = 1'b0;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        do_read    = 1'b0;
        sel_pos    = CW'(in_index);
        count_next = count_reg;
        case (mode)
            spq_pkg::MODE_ENQUEUE:
            begin
                ok         = (count_reg != FULL_COUNT);
                do_ins     = ok;
                count_next = ok ? count_reg + 1'b1 : count_reg;
            end
            spq_pkg::MODE_POP:
            begin
                sel_pos    = count_reg - 1'b1;
                ok         = (count_reg != '0);
                do_del     = ok;
                do_read    = ok;
                count_next = ok ? count_reg - 1'b1 : count_reg;
            end
            spq_pkg::MODE_PEEK_TOP:
            begin
                sel_pos = count_reg - 1'b1;
                ok      = (count_reg != '0);
                do_read = ok;
            end
            spq_pkg::MODE_PEEK_AT:
            begin
                ok      = (CW'(in_index) < count_reg);
                do_read = ok;
            end
            spq_pkg::MODE_REMOVE_AT:
            begin
                ok         = (CW'(in_index) < count_reg);
                do_del     = ok;
                do_read    = ok;
                count_next = ok ? count_reg - 1'b1 : count_reg;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            localparam logic [CW-1:0] CELL_IDX = CW'(i);

            spq_pkg::cell_ctrl_t       ctrl;
            logic                      left_le;
            logic [DATA_WIDTH-1:0]     left_data;
            logic [PRIORITY_WIDTH-1:0] left_prio;
            logic [DATA_WIDTH-1:0]     right_data;
            logic [PRIORITY_WIDTH-1:0] right_prio;

            assign ctrl.ins         = accept && do_ins;
            assign ctrl.del         = accept && do_del;
            assign ctrl.valid       = (CELL_IDX < count_reg);
            assign ctrl.at_or_after = (CELL_IDX >= sel_pos);

            if (i == 0)
            begin : g_first
                assign left_le   = 1'b1;
                assign left_data = in_data;
                assign left_prio = in_prio;
            end
            else
            begin : g_inner_left
                assign left_le   = cell_le[i-1];
                assign left_data = cell_data[i-1];
                assign left_prio = cell_prio[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_data = cell_data[i];
                assign right_prio = cell_prio[i];
            end
            else
            begin : g_inner_right
                assign right_data = cell_data[i+1];
                assign right_prio = cell_prio[i+1];
            end

            spq_cell #(
                .DATA_WIDTH     (DATA_WIDTH),
                .PRIORITY_WIDTH (PRIORITY_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .new_data   (in_data),
                .new_prio   (in_prio),
                .left_le    (left_le),
                .left_data  (left_data),
                .left_prio  (left_prio),
                .right_data (right_data),
                .right_prio (right_prio),
                .le         (cell_le[i]),
                .data       (cell_data[i]),
                .prio       (cell_prio[i])
            );
        end
    endgenerate

    always_comb
    begin
        sel_data = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            if (CW'(k) == sel_pos)
            begin
                sel_data = sel_data | cell_data[k];
            end
        end
    end

    assign dout = do_read ? sel_data : '0;

    always_comb
    begin
        m_tdata_next                          = '0;
        m_tdata_next[0]                       = ok;
        m_tdata_next[DATA_WIDTH:1]            = dout;
        m_tdata_next[DATA_WIDTH+CW:DATA_WIDTH+1] = count_next;
        m_tdata_next[DATA_WIDTH+CW+1]         = (count_next == '0);
        m_tdata_next[DATA_WIDTH+CW+2]         = (count_next == FULL_COUNT);
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (accept)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

>>> rtl/spq_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on sorted_priority_queue_unit.
module spq_checker #(
    parameter int DEPTH          = 16,
    parameter int DATA_WIDTH     = 32
) (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((DATA_WIDTH + $clog2(DEPTH + 1) + 3 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic                  res_ok;
    logic [DATA_WIDTH-1:0] res_data;
    logic [CW-1:0]         res_count;
    logic                  res_empty;
    logic                  res_full;

    assign res_ok    = m_tdata[0];
    assign res_data  = m_tdata[DATA_WIDTH:1];
    assign res_count = m_tdata[DATA_WIDTH+CW:DATA_WIDTH+1];
    assign res_empty = m_tdata[DATA_WIDTH+CW+1];
    assign res_full  = m_tdata[DATA_WIDTH+CW+2];

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("transfer in gave no result next cycle");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((res_empty == (res_count == '0)) && (res_full == (res_count == FULL_COUNT))))
        else $error("empty or full flag disagrees with count");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !res_ok) |-> (res_data == '0))
        else $error("rejected transfer returned data");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_count <= FULL_COUNT))
        else $error("count above capacity");

endmodule

bind sorted_priority_queue_unit spq_checker #(
    .DEPTH          (DEPTH),
    .DATA_WIDTH     (DATA_WIDTH)
) u_spq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> dv/sorted_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue_unit: directed rows, then random operations.
// Holds its own model of the sorted array and checks every result transfer against it or a row's fixed outcome.
// Depends on spq_pkg and the sorted_priority_queue_unit RTL.
module sorted_priority_queue_unit_tb;

    localparam int DEPTH       = 16;
    localparam int WORK_ITEMS  = 1700;
    localparam int IDLE_LIMIT  = 500;

    localparam spq_pkg::mode_t MODE_SPARE_5 = 3'd5;
    localparam spq_pkg::mode_t MODE_SPARE_6 = 3'd6;
    localparam spq_pkg::mode_t MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        spq_pkg::mode_t mode;
        logic [31:0]    data_value;
        logic [15:0]    priority_req;
        logic [3:0]     index;
    } queue_op_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] data_out;
        logic [4:0]  count;
        logic        empty_res;
        logic        full_res;
    } queue_res_t;

    typedef struct {
        queue_op_t  op;
        int         reps;
        bit         typed;
        queue_res_t res;
    } dir_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    sorted_priority_queue_unit #(
        .DEPTH          (DEPTH),
        .DATA_WIDTH     (32),
        .PRIORITY_WIDTH (16)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // model state of the sorted array
    logic [31:0] qm_data [DEPTH];
    logic [15:0] qm_prio [DEPTH];
    int          qm_count;

    queue_res_t  pending_results[$];
    dir_row_t    dir_rows[$];

    int  mismatches   = 0;
    int  results_seen = 0;
    int  rejected     = 0;
    int  deepest      = 0;
    int  idle_cycles  = 0;
    int  burst_left   = 0;
    int  ops_by_mode[8];
    bit  sending      = 1'b1;

    function automatic logic [31:0] take_entry(input int pos);
        logic [31:0] d;
        d = qm_data[pos];
        for (int i = pos; i + 1 < qm_count; i++)
        begin
            qm_data[i] = qm_data[i + 1];
            qm_prio[i] = qm_prio[i + 1];
        end
        qm_count--;
        return d;
    endfunction

    function automatic queue_res_t apply_queue_op(input queue_op_t op);
        queue_res_t r;
        int         pos;
        r = '0;
        case (op.mode)
            spq_pkg::MODE_ENQUEUE:
                if (qm_count < DEPTH)
                begin
                    pos = qm_count;
                    while (pos > 0 && qm_prio[pos - 1] > op.priority_req)
                    begin
                        qm_data[pos] = qm_data[pos - 1];
                        qm_prio[pos] = qm_prio[pos - 1];
                        pos--;
                    end
                    qm_data[pos] = op.data_value;
                    qm_prio[pos] = op.priority_req;
                    qm_count++;
                    r.ok = 1'b1;
                end
            spq_pkg::MODE_POP:
                if (qm_count > 0)
                begin
                    r.data_out = take_entry(qm_count - 1);
                    r.ok       = 1'b1;
                end
            spq_pkg::MODE_PEEK_TOP:
                if (qm_count > 0)
                begin
                    r.data_out = qm_data[qm_count - 1];
                    r.ok       = 1'b1;
                end
            spq_pkg::MODE_PEEK_AT:
                if (int'(op.index) < qm_count)
                begin
                    r.data_out = qm_data[op.index];
                    r.ok       = 1'b1;
                end
            spq_pkg::MODE_REMOVE_AT:
                if (int'(op.index) < qm_count)
                begin
                    r.data_out = take_entry(int'(op.index));
                    r.ok       = 1'b1;
                end
            default: ;
        endcase
        r.count     = 5'(qm_count);
        r.empty_res = (qm_count == 0);
        r.full_res  = (qm_count == DEPTH);
        return r;
    endfunction

    function automatic queue_res_t outcome(input logic ok, input logic [31:0] d, input int cnt);
        queue_res_t r;
        r.ok        = ok;
        r.data_out  = d;
        r.count     = 5'(cnt);
        r.empty_res = (cnt == 0);
        r.full_res  = (cnt == DEPTH);
        return r;
    endfunction

    task automatic add_row(input spq_pkg::mode_t m, input logic [31:0] d, input logic [15:0] p,
                           input logic [3:0] idx, input int reps, input bit typed,
                           input queue_res_t res);
        dir_row_t row;
        row.op    = '{mode: m, data_value: d, priority_req: p, index: idx};
        row.reps  = reps;
        row.typed = typed;
        row.res   = res;
        dir_rows.push_back(row);
    endtask

    // drive one operation, hold it until the transfer, then record its result
    task automatic push_op(input queue_op_t op, input bit typed, input queue_res_t typed_res);
        int         gap;
        queue_res_t r;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, op.index, op.priority_req, op.data_value, op.mode};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        r = apply_queue_op(op);
        pending_results.push_back(typed ? typed_res : r);
        ops_by_mode[op.mode]++;
        if (!r.ok)
            rejected++;
        if (qm_count > deepest)
            deepest = qm_count;
    endtask

    // receiver: check each result transfer, then choose the next ready level
    int stall_style = 0;
    int stall_left  = 0;
    int stall_phase = 0;

    always @(posedge clk)
    begin
        queue_res_t got;
        queue_res_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (sending || pending_results.size() != 0)
                idle_cycles <= idle_cycles + 1;

            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[0], m_tdata[32:1], m_tdata[37:33], m_tdata[38], m_tdata[39]};
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with nothing outstanding: %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.ok !== want.ok)
                    begin
                        $error("ok: expected %0d, got %0d", want.ok, got.ok);
                        mismatches++;
                    end
                    if (got.data_out !== want.data_out)
                    begin
                        $error("data_out: expected %h, got %h", want.data_out, got.data_out);
                        mismatches++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        mismatches++;
                    end
                    if (got.empty_res !== want.empty_res)
                    begin
                        $error("empty_res: expected %0d, got %0d",
                               want.empty_res, got.empty_res);
                        mismatches++;
                    end
                    if (got.full_res !== want.full_res)
                    begin
                        $error("full_res: expected %0d, got %0d", want.full_res, got.full_res);
                        mismatches++;
                    end
                end
            end
        end

        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(10, 120);
        end
        stall_left--;
        stall_phase++;
        case (stall_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (stall_phase % 3 == 0);
            default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        queue_op_t op;
        queue_res_t none;
        int work_done;
        int phase_left;
        int fill_bias;
        int pick;

        none       = '0;
        work_done  = 0;
        phase_left = 0;
        fill_bias  = 50;
        qm_count   = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            qm_data[i] = '0;
            qm_prio[i] = '0;
        end

        add_row(spq_pkg::MODE_POP,       '0, '0, 4'd0,  1, 1, outcome(0, '0, 0));
        add_row(spq_pkg::MODE_PEEK_TOP,  '0, '0, 4'd0,  1, 1, outcome(0, '0, 0));
        add_row(spq_pkg::MODE_PEEK_AT,   '0, '0, 4'd0,  1, 1, outcome(0, '0, 0));
        add_row(spq_pkg::MODE_REMOVE_AT, '0, '0, 4'd15, 1, 1, outcome(0, '0, 0));
        add_row(MODE_SPARE_5,   '1, '1, 4'd15, 1, 1, outcome(0, '0, 0));
        add_row(MODE_SPARE_7,   '1, '1, 4'd0,  1, 1, outcome(0, '0, 0));
        add_row(spq_pkg::MODE_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 4'd0, 1, 1, outcome(1, '0, 1));
        add_row(spq_pkg::MODE_ENQUEUE, 32'h0000_0000, 16'h0000, 4'd0, 1, 1, outcome(1, '0, 2));
        add_row(spq_pkg::MODE_ENQUEUE, 32'h0000_0001, 16'hFFFF, 4'd0, 1, 1, outcome(1, '0, 3));
        add_row(spq_pkg::MODE_PEEK_TOP,  '0, '0, 4'd0, 1, 0, none);
        add_row(spq_pkg::MODE_PEEK_AT,   '0, '0, 4'd0, 1, 0, none);
        add_row(spq_pkg::MODE_PEEK_AT,   '0, '0, 4'd2, 1, 0, none);
        add_row(spq_pkg::MODE_PEEK_AT,   '0, '0, 4'd3, 1, 1, outcome(0, '0, 3));
        add_row(spq_pkg::MODE_REMOVE_AT, '0, '0, 4'd1, 1, 0, none);
        add_row(spq_pkg::MODE_POP,       '0, '0, 4'd0, 2, 0, none);
        add_row(spq_pkg::MODE_ENQUEUE, 32'h1000_0000, 16'h0100, 4'd0, DEPTH, 0, none);
        add_row(spq_pkg::MODE_ENQUEUE, 32'hDEAD_BEEF, 16'h0000, 4'd0, 1, 1,
                outcome(0, '0, DEPTH));
        add_row(MODE_SPARE_6,   '1, '1, 4'd7, 1, 1, outcome(0, '0, DEPTH));
        add_row(spq_pkg::MODE_PEEK_AT,   '0, '0, 4'd15, 1, 0, none);
        add_row(spq_pkg::MODE_REMOVE_AT, '0, '0, 4'd15, 1, 0, none);
        add_row(spq_pkg::MODE_REMOVE_AT, '0, '0, 4'd0,  1, 0, none);
        add_row(spq_pkg::MODE_PEEK_AT,   '0, '0, 4'd14, 1, 1, outcome(0, '0, 14));
        add_row(spq_pkg::MODE_ENQUEUE, 32'hA5A5_A5A5, 16'h8000, 4'd0, 1, 0, none);
        add_row(spq_pkg::MODE_PEEK_TOP,  '0, '0, 4'd0, 1, 0, none);
        add_row(spq_pkg::MODE_POP,       '0, '0, 4'd0, DEPTH - 1, 0, none);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[n])
        begin
            for (int k = 0; k < dir_rows[n].reps; k++)
            begin
                op = dir_rows[n].op;
                if (dir_rows[n].reps > 1)
                begin
                    op.data_value   = op.data_value + 32'(k);
                    op.priority_req = op.priority_req + 16'((k * 7) % 5);
                end
                push_op(op, dir_rows[n].typed, dir_rows[n].res);
            end
        end

        // alternate filling and draining stretches so every fill level is visited
        while (work_done < WORK_ITEMS)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       fill_bias = 80;
                    1:       fill_bias = 20;
                    default: fill_bias = 50;
                endcase
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;

            pick = $urandom_range(0, 99);
            if (pick < 3)
                op.mode = spq_pkg::mode_t'($urandom_range(5, 7));
            else if (pick < 3 + fill_bias)
                op.mode = spq_pkg::MODE_ENQUEUE;
            else
                op.mode = spq_pkg::mode_t'($urandom_range(1, 4));

            op.data_value = $urandom;
            case ($urandom_range(0, 9))
                0:       op.priority_req = 16'h0000;
                1:       op.priority_req = 16'hFFFF;
                2, 3, 4, 5: op.priority_req = 16'($urandom_range(0, 7));
                default: op.priority_req = 16'($urandom);
            endcase
            if (qm_count > 0 && $urandom_range(0, 3) != 0)
                op.index = 4'($urandom_range(0, qm_count - 1));
            else
                op.index = 4'($urandom_range(0, 15));

            push_op(op, 1'b0, none);
            if (op.mode <= spq_pkg::MODE_REMOVE_AT)
                work_done++;
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        sending = 1'b0;
        repeat (5) @(posedge clk);

        $display("Ran %0d operations (%0d spare codes), checked %0d results, %0d rejected.",
                 ops_by_mode[0] + ops_by_mode[1] + ops_by_mode[2] + ops_by_mode[3]
                 + ops_by_mode[4] + ops_by_mode[5] + ops_by_mode[6] + ops_by_mode[7],
                 ops_by_mode[5] + ops_by_mode[6] + ops_by_mode[7], results_seen, rejected);
        $display("Enqueue %0d, pop %0d, peek top %0d, peek at %0d, remove at %0d; max fill %0d.",
                 ops_by_mode[0], ops_by_mode[1], ops_by_mode[2], ops_by_mode[3],
                 ops_by_mode[4], deepest);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
